// ===== sv/tis_pkg.sv =====
package tis_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WIN_W  = 16;
    localparam int unsigned POS_W  = 4;

    localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_IAC = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_SB  = 8'hFA;
    localparam logic [BYTE_W-1:0] OPT_NAWS = 8'h1F;

    // Positions inside a command; idle means outside any command.
    localparam logic [POS_W-1:0] POS_IDLE    = 4'd0;
    localparam logic [POS_W-1:0] POS_CMD     = 4'd1;
    localparam logic [POS_W-1:0] POS_OPT     = 4'd2;
    localparam logic [POS_W-1:0] POS_COLS_HI = 4'd3;
    localparam logic [POS_W-1:0] POS_COLS_LO = 4'd4;
    localparam logic [POS_W-1:0] POS_ROWS_HI = 4'd5;
    localparam logic [POS_W-1:0] POS_ROWS_LO = 4'd6;
    localparam logic [POS_W-1:0] POS_LAST    = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              size_update;
        logic [WIN_W-1:0]  win_cols;
        logic [WIN_W-1:0]  win_rows;
    } tis_result_t;

endpackage

// ===== sv/tis_in_if.sv =====
interface tis_in_if;
    import tis_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== sv/tis_out_if.sv =====
interface tis_out_if;
    import tis_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              size_update;
    logic [WIN_W-1:0]  win_cols;
    logic [WIN_W-1:0]  win_rows;

    modport source (
        output valid, output out_byte, output out_valid, output size_update,
        output win_cols, output win_rows, input ready
    );
    modport sink (
        input valid, input out_byte, input out_valid, input size_update,
        input win_cols, input win_rows, output ready
    );
endinterface

// ===== sv/tis_filter.sv =====
module tis_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [tis_pkg::BYTE_W-1:0]    in_byte,
    output tis_pkg::tis_result_t          res
);
    import tis_pkg::*;

    logic [POS_W-1:0]  seq_pos_reg, seq_pos_next;
    logic              cmd_was_sb_reg, cmd_was_sb_next;
    logic              prev_cr_reg, prev_cr_next;
    logic [WIN_W-1:0]  cols_latch_reg, cols_latch_next;
    logic [BYTE_W-1:0] rows_high_reg, rows_high_next;
    logic [BYTE_W-1:0] rows_low_reg, rows_low_next;
    logic [POS_W-1:0]  pos;

    always_comb
    begin
        pos             = (seq_pos_reg > POS_LAST) ? POS_IDLE : seq_pos_reg;
        seq_pos_next    = pos;
        cmd_was_sb_next = cmd_was_sb_reg;
        prev_cr_next    = prev_cr_reg;
        cols_latch_next = cols_latch_reg;
        rows_high_next  = rows_high_reg;
        rows_low_next   = rows_low_reg;
        res             = '0;

        case (pos)
            POS_IDLE:
            begin
                if (in_byte == BYTE_IAC)
                begin
                    seq_pos_next = POS_CMD;
                    prev_cr_next = 1'b0;
                end
                else if (prev_cr_reg && (in_byte == BYTE_LF || in_byte == BYTE_NUL))
                begin
                    prev_cr_next = 1'b0;
                end
                else
                begin
                    res.out_byte  = in_byte;
                    res.out_valid = 1'b1;
                    prev_cr_next  = (in_byte == BYTE_CR);
                end
            end
            POS_CMD:
            begin
                cmd_was_sb_next = (in_byte == BYTE_SB);
                seq_pos_next    = POS_OPT;
            end
            POS_OPT:
            begin
                if (cmd_was_sb_reg && in_byte == OPT_NAWS)
                begin
                    seq_pos_next = POS_COLS_HI;
                end
                else
                begin
                    cmd_was_sb_next = 1'b0;
                    seq_pos_next    = POS_IDLE;
                end
            end
            POS_COLS_HI:
            begin
                cols_latch_next = {in_byte, cols_latch_reg[BYTE_W-1:0]};
                seq_pos_next    = pos + 4'd1;
            end
            POS_COLS_LO:
            begin
                cols_latch_next = {cols_latch_reg[WIN_W-1:BYTE_W], in_byte};
                seq_pos_next    = pos + 4'd1;
            end
            POS_ROWS_HI:
            begin
                rows_high_next = in_byte;
                seq_pos_next   = pos + 4'd1;
            end
            POS_ROWS_LO:
            begin
                rows_low_next = in_byte;
                seq_pos_next  = pos + 4'd1;
            end
            POS_LAST:
            begin
                res.size_update = 1'b1;
                res.win_cols    = cols_latch_reg;
                res.win_rows    = {rows_high_reg, rows_low_reg};
                cmd_was_sb_next = 1'b0;
                seq_pos_next    = POS_IDLE;
            end
            default:
            begin
                seq_pos_next = pos + 4'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_pos_reg    <= POS_IDLE;
            cmd_was_sb_reg <= 1'b0;
            prev_cr_reg    <= 1'b0;
            cols_latch_reg <= '0;
            rows_high_reg  <= '0;
            rows_low_reg   <= '0;
        end
        else if (accept)
        begin
            seq_pos_reg    <= seq_pos_next;
            cmd_was_sb_reg <= cmd_was_sb_next;
            prev_cr_reg    <= prev_cr_next;
            cols_latch_reg <= cols_latch_next;
            rows_high_reg  <= rows_high_next;
            rows_low_reg   <= rows_low_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_pos_reg <= POS_LAST)
        else $error("command position out of range");

    a_iac_opens_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && seq_pos_reg == POS_IDLE && in_byte == BYTE_IAC |=> seq_pos_reg == POS_CMD)
        else $error("IAC did not open a command");

    a_cmd_clears_cr: assert property (@(posedge clk) disable iff (!rst_n)
        seq_pos_reg != POS_IDLE |-> !prev_cr_reg)
        else $error("carriage return flag held inside a command");

endmodule

// ===== sv/tis_out_buf.sv =====
module tis_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tis_pkg::tis_result_t res,
    output logic                 ready,
    tis_out_if.source            tx
);
    import tis_pkg::*;

    tis_result_t main_reg, main_next;
    tis_result_t skid_reg, skid_next;
    logic        main_vld_reg, main_vld_next;
    logic        skid_vld_reg, skid_vld_next;
    logic        pop;

    assign pop   = main_vld_reg && tx.ready;
    assign ready = !skid_vld_reg;

    always_comb
    begin
        main_next     = main_reg;
        skid_next     = skid_reg;
        main_vld_next = main_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg)
        begin
            if (pop || !main_vld_reg)
            begin
                main_next     = skid_reg;
                main_vld_next = 1'b1;
                skid_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (pop || !main_vld_reg)
            begin
                main_next     = res;
                main_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = res;
                skid_vld_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign tx.valid       = main_vld_reg;
    assign tx.out_byte    = main_reg.out_byte;
    assign tx.out_valid   = main_reg.out_valid;
    assign tx.size_update = main_reg.size_update;
    assign tx.win_cols    = main_reg.win_cols;
    assign tx.win_rows    = main_reg.win_rows;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> main_vld_reg)
        else $error("skid stage holds a beat ahead of the output stage");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && !pop |=> skid_vld_reg && $stable(skid_reg))
        else $error("skid beat lost while the output stalled");

endmodule

// ===== sv/telnet_iac_stripper_core.sv =====
// Channel  Direction  Beat contents
// rx       sink       in_byte
// tx       source     out_byte, out_valid, size_update, win_cols, win_rows
//
// One beat is accepted per clock while rx.ready is high; every accepted beat yields exactly one tx beat.
// The command decoder updates its state in the accepting cycle and the result is
// registered in the output buffer's main entry, or in its skid entry while tx stalls.
// A two-entry output buffer lets rx take a new beat while a result waits; rx.ready
// drops only when both entries are full.
// Reset is asynchronous and active low and returns the decoder to outside any command.
module telnet_iac_stripper_core (
    input  logic      clk,
    input  logic      rst_n,
    tis_in_if.sink    rx,
    tis_out_if.source tx
);
    import tis_pkg::*;

    tis_result_t res;
    logic        buf_ready;
    logic        accept;

    assign rx.ready = buf_ready;
    assign accept   = rx.valid && buf_ready;

    tis_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (rx.in_byte),
        .res     (res)
    );

    tis_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .res   (res),
        .ready (buf_ready),
        .tx    (tx)
    );

endmodule
